[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the variant finder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/lfvf_pkg.sv]
// ---------------------------------------------------------------------------
// lfvf_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lfvf_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_REGIONS_DEF = 64;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int FREQ_W  = 7;
  localparam int LEN_W   = 13;
  localparam int START_W = 12;
  localparam int PCT     = 100;

  localparam int  ADDR_W     = 3;
  localparam int  DATA_W     = 32;
  localparam logic REG_FREQ  = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  typedef struct packed {
    logic col_load;
    logic col_proc;
    logic pair_init;
    logic r_rd;
    logic r_take;
    logic r_skip;
    logic l_rd;
    logic nest_inc;
    logic nest_dec;
    logic l_take;
    logic wl_rd;
    logic wr_rd;
    logic w_take;
    logic j_rd;
    logic j_mul;
    logic j_next;
    logic add;
    logic e_init;
    logic e_rd;
    logic e_load;
    logic e_none;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic rcnt_zero;
    logic rcount_zero;
    logic lcnt_zero;
    logic anchor_right;
    logic too_long;
    logic nested_zero;
    logic j_done;
    logic j_low;
    logic ocnt_zero;
    logic out_valid;
  } status_t;

endpackage

[src/lfvf_ctrl.sv]
// ---------------------------------------------------------------------------
// lfvf_ctrl
// Sequencer for column loading, anchor pairing and region readout.
// ---------------------------------------------------------------------------
module lfvf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lfvf_pkg::status_t sts,
  output lfvf_pkg::cmd_t    cmd
);
  import lfvf_pkg::*;

  typedef enum logic [4:0] {
    IDLE, COL, P_INIT, R_CHK, R_WAIT, L_ISS, L_WAIT, W_LRD, W_RRD, W_TAKE,
    J_ISS, J_WAIT, J_CMP, ADD, E_START, E_ISS, E_WAIT, E_HOLD, CLEAR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.col_load = 1'b1;
          state_next = COL;
        end
      end
      COL: begin
        cmd.col_proc = 1'b1;
        state_next = sts.last ? P_INIT : IDLE;
      end
      P_INIT: begin
        cmd.pair_init = 1'b1;
        state_next = R_CHK;
      end
      R_CHK: begin
        if (sts.rcnt_zero) begin
          state_next = E_START;
        end else begin
          cmd.r_rd = 1'b1;
          state_next = R_WAIT;
        end
      end
      R_WAIT: begin
        if (sts.anchor_right) begin
          cmd.r_take = 1'b1;
          state_next = L_ISS;
        end else begin
          cmd.r_skip = 1'b1;
          state_next = R_CHK;
        end
      end
      L_ISS: begin
        if (sts.lcnt_zero) begin
          cmd.r_skip = 1'b1;
          state_next = R_CHK;
        end else begin
          cmd.l_rd = 1'b1;
          state_next = L_WAIT;
        end
      end
      L_WAIT: begin
        if (sts.too_long) begin
          cmd.r_skip = 1'b1;
          state_next = R_CHK;
        end else if (sts.anchor_right) begin
          cmd.nest_inc = 1'b1;
          state_next = L_ISS;
        end else if (!sts.nested_zero) begin
          cmd.nest_dec = 1'b1;
          state_next = L_ISS;
        end else begin
          cmd.l_take = 1'b1;
          state_next = W_LRD;
        end
      end
      W_LRD: begin
        cmd.wl_rd = 1'b1;
        state_next = W_RRD;
      end
      W_RRD: begin
        cmd.wr_rd = 1'b1;
        state_next = W_TAKE;
      end
      W_TAKE: begin
        cmd.w_take = 1'b1;
        state_next = J_ISS;
      end
      J_ISS: begin
        if (sts.j_done) begin
          state_next = ADD;
        end else begin
          cmd.j_rd = 1'b1;
          state_next = J_WAIT;
        end
      end
      J_WAIT: begin
        cmd.j_mul = 1'b1;
        state_next = J_CMP;
      end
      J_CMP: begin
        if (sts.j_low) begin
          cmd.j_next = 1'b1;
          state_next = J_ISS;
        end else begin
          cmd.r_skip = 1'b1;
          state_next = R_CHK;
        end
      end
      ADD: begin
        cmd.add = 1'b1;
        state_next = R_CHK;
      end
      E_START: begin
        cmd.e_init = 1'b1;
        if (sts.rcount_zero) begin
          cmd.e_none = 1'b1;
          state_next = E_HOLD;
        end else begin
          state_next = E_ISS;
        end
      end
      E_ISS: begin
        cmd.e_rd = 1'b1;
        state_next = E_WAIT;
      end
      E_WAIT: begin
        cmd.e_load = 1'b1;
        state_next = E_HOLD;
      end
      E_HOLD: begin
        if (!sts.out_valid) begin
          state_next = sts.ocnt_zero ? CLEAR : E_ISS;
        end
      end
      CLEAR: begin
        cmd.clear = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != IDLE);
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_to_col, clk, rst, in_valid && !in_stall, state == COL, "accepted beat not processed")
  `ASSERT_IMPL(a_hold_out, clk, rst, state == E_HOLD && $past(state) == E_WAIT, sts.out_valid, "result not loaded")

endmodule

[src/lfvf_dp.sv]
// ---------------------------------------------------------------------------
// lfvf_dp
// Column, anchor and region stores with the ratio test arithmetic.
// ---------------------------------------------------------------------------
module lfvf_dp #(
  parameter int MAX_COLUMNS = lfvf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_REGIONS = lfvf_pkg::MAX_REGIONS_DEF,
  parameter int COUNT_BITS  = lfvf_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lfvf_pkg::cmd_t                cmd,
  output lfvf_pkg::status_t             sts,
  input  logic [lfvf_pkg::FREQ_W-1:0]   freq_percent,
  input  logic [lfvf_pkg::LEN_W-1:0]    max_region_len,
  input  logic [COUNT_BITS-1:0]         count_a,
  input  logic [COUNT_BITS-1:0]         count_c,
  input  logic [COUNT_BITS-1:0]         count_g,
  input  logic [COUNT_BITS-1:0]         count_t,
  input  logic                          last_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfvf_pkg::START_W-1:0]  region_start,
  output logic [lfvf_pkg::LEN_W-1:0]    region_length,
  output logic                          region_valid,
  output logic                          overflow,
  output logic                          last_result
);
  import lfvf_pkg::*;

  localparam int CW  = COUNT_BITS + 2;
  localparam int TW  = CW + 8;
  localparam int PW  = $clog2(MAX_COLUMNS);
  localparam int CIW = $clog2(MAX_COLUMNS + 1);
  localparam int LW  = (CIW > LEN_W) ? CIW : LEN_W;
  localparam int RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW = $clog2(MAX_REGIONS + 1);

  logic [CW-1:0]   cov_mem [MAX_COLUMNS];
  logic [PW:0]     anchor_mem [MAX_COLUMNS];
  logic [PW+LEN_W-1:0] region_mem [MAX_REGIONS];

  logic [CW-1:0]   cov_in, prev, cov_rd;
  logic            last;
  logic [CIW-1:0]  col_idx, acount, rcnt, lcnt, nested;
  logic [PW:0]     anchor_rd;
  logic [PW-1:0]   rpos, lpos, j;
  logic [LEN_W-1:0] len;
  logic [TW-1:0]   thl, thr, prod;
  logic [RCW-1:0]  rcount, ocnt;
  logic            ovf;
  logic [PW+LEN_W-1:0] region_rd;

  logic [CW-1:0]   sum;
  logic [7:0]      f1;
  logic            low_l, low_r;
  logic [PW-1:0]   apos, col_pos;
  logic [LW-1:0]   len_c;
  logic [PW-1:0]   cov_raddr;
  logic [PW+START_W-1:0] start_ext;

  assign sum = CW'(count_a) + CW'(count_c) + CW'(count_g) + CW'(count_t);
  assign f1  = {1'b0, freq_percent} + 8'd1;
  assign col_pos = col_idx[PW-1:0];
  assign low_l = TW'(cov_in) * TW'(PCT) < TW'(f1) * TW'(prev);
  assign low_r = TW'(prev) * TW'(PCT) < TW'(f1) * TW'(cov_in);
  assign apos  = anchor_rd[PW:1];
  assign len_c = LW'(rpos) - LW'(apos) + LW'(1);

  always_comb begin
    if (cmd.wl_rd) begin
      cov_raddr = lpos - PW'(1);
    end else if (cmd.wr_rd) begin
      cov_raddr = rpos + PW'(1);
    end else begin
      cov_raddr = j;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.col_proc && col_idx < CIW'(MAX_COLUMNS)) begin
      cov_mem[col_pos] <= cov_in;
      if (col_idx != '0 && low_l) begin
        anchor_mem[acount[PW-1:0]] <= {col_pos, 1'b0};
      end else if (col_idx != '0 && low_r) begin
        anchor_mem[acount[PW-1:0]] <= {col_pos - PW'(1), 1'b1};
      end
    end
    if (cmd.add && rcount < RCW'(MAX_REGIONS)) begin
      region_mem[rcount[RAW-1:0]] <= {lpos, len};
    end
    cov_rd <= cov_mem[cov_raddr];
    anchor_rd <= anchor_mem[cmd.l_rd ? lcnt[PW-1:0] - PW'(1) : rcnt[PW-1:0] - PW'(1)];
    region_rd <= region_mem[ocnt[RAW-1:0] - RAW'(1)];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      cov_in <= (sum == '0) ? CW'(1) : sum;
      last   <= last_column;
    end
    if (cmd.r_take) begin
      rpos <= apos;
    end
    if (cmd.l_take) begin
      lpos <= apos;
      len  <= len_c[LEN_W-1:0];
    end
    if (cmd.wr_rd) begin
      thl <= TW'(f1) * TW'(cov_rd);
    end
    if (cmd.w_take) begin
      thr <= TW'(f1) * TW'(cov_rd);
      j   <= lpos + PW'(1);
    end else if (cmd.j_next) begin
      j <= j + PW'(1);
    end
    if (cmd.j_mul) begin
      prod <= TW'(cov_rd) * TW'(PCT);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      col_idx <= '0;
      acount  <= '0;
      prev    <= '0;
      rcount  <= '0;
      ovf     <= 1'b0;
    end else begin
      if (cmd.col_proc && col_idx < CIW'(MAX_COLUMNS)) begin
        prev    <= cov_in;
        col_idx <= col_idx + CIW'(1);
        if (col_idx != '0 && (low_l || low_r)) begin
          acount <= acount + CIW'(1);
        end
      end
      if (cmd.add) begin
        if (rcount < RCW'(MAX_REGIONS)) begin
          rcount <= rcount + RCW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt   <= '0;
      lcnt   <= '0;
      nested <= '0;
      ocnt   <= '0;
    end else begin
      if (cmd.pair_init) begin
        rcnt <= acount;
      end else if (cmd.r_skip) begin
        rcnt <= rcnt - CIW'(1);
      end else if (cmd.add) begin
        rcnt <= lcnt - CIW'(1);
      end
      if (cmd.r_take) begin
        lcnt   <= rcnt - CIW'(1);
        nested <= '0;
      end else if (cmd.nest_inc) begin
        lcnt   <= lcnt - CIW'(1);
        nested <= nested + CIW'(1);
      end else if (cmd.nest_dec) begin
        lcnt   <= lcnt - CIW'(1);
        nested <= nested - CIW'(1);
      end
      if (cmd.e_init) begin
        ocnt <= rcount;
      end else if (cmd.e_load) begin
        ocnt <= ocnt - RCW'(1);
      end
    end
  end

  // output register
  assign start_ext = (PW + START_W)'(region_rd[PW+LEN_W-1:LEN_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.e_load || cmd.e_none) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.e_none) begin
      region_start  <= '0;
      region_length <= '0;
      region_valid  <= 1'b0;
      overflow      <= 1'b0;
      last_result   <= 1'b1;
    end else if (cmd.e_load) begin
      region_start  <= start_ext[START_W-1:0];
      region_length <= region_rd[LEN_W-1:0];
      region_valid  <= 1'b1;
      overflow      <= ovf;
      last_result   <= (ocnt == RCW'(1));
    end
  end

  always_comb begin
    sts.last         = last;
    sts.rcnt_zero    = (rcnt == '0);
    sts.rcount_zero  = (rcount == '0);
    sts.lcnt_zero    = (lcnt == '0);
    sts.anchor_right = anchor_rd[0];
    sts.too_long     = len_c > LW'(max_region_len);
    sts.nested_zero  = (nested == '0);
    sts.j_done       = (j >= rpos);
    sts.j_low        = (prod < thl) && (prod < thr);
    sts.ocnt_zero    = (ocnt == '0);
    sts.out_valid    = out_valid;
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_rcount_max, clk, rst, 1'b1, rcount <= RCW'(MAX_REGIONS), "region count past capacity")
  `ASSERT_IMPL(a_ovf_full, clk, rst, ovf, rcount == RCW'(MAX_REGIONS), "overflow with free slots")
  `ASSERT_IMPL(a_anchor_cnt, clk, rst, 1'b1, acount <= col_idx, "more anchors than columns")

endmodule

[src/low_frequency_variant_finder.sv]
// ---------------------------------------------------------------------------
// low_frequency_variant_finder
// Finds low-coverage variant regions from a streamed column profile.
// ---------------------------------------------------------------------------
// Each column beat is captured, then stored and anchor-tested, and the input
// stalls while it is stored. On the beat with last_column set the block
// stalls its input and runs the pairing pass over the stored anchors: the
// backward anchor scan, the interior column checks and the candidate pairs
// are all paced by the single read port of the coverage and anchor memories.
// Regions then come out in ascending order, each only once the previous
// beat has left the output; a contig with no region gives one beat with
// region_valid low. A final clear state precedes the next contig.
module low_frequency_variant_finder #(
  parameter int MAX_COLUMNS = lfvf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_REGIONS = lfvf_pkg::MAX_REGIONS_DEF,
  parameter int COUNT_BITS  = lfvf_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfvf_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfvf_pkg::DATA_W-1:0]   pwdata,
  output logic [lfvf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [COUNT_BITS-1:0]         count_a,
  input  logic [COUNT_BITS-1:0]         count_c,
  input  logic [COUNT_BITS-1:0]         count_g,
  input  logic [COUNT_BITS-1:0]         count_t,
  input  logic                          last_column,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfvf_pkg::START_W-1:0]  region_start,
  output logic [lfvf_pkg::LEN_W-1:0]    region_length,
  output logic                          region_valid,
  output logic                          overflow,
  output logic                          last_result
);
  import lfvf_pkg::*;

  logic [FREQ_W-1:0] freq_percent;
  logic [LEN_W-1:0]  max_region_len;
  cmd_t    cmd;
  status_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_percent   <= FREQ_W'(5);
      max_region_len <= LEN_W'(20);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_FREQ:   freq_percent   <= pwdata[FREQ_W-1:0];
        REG_MAXLEN: max_region_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FREQ:   prdata = DATA_W'(freq_percent);
      REG_MAXLEN: prdata = DATA_W'(max_region_len);
      default:    prdata = '0;
    endcase
  end

  lfvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfvf_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_REGIONS (MAX_REGIONS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .freq_percent   (freq_percent),
    .max_region_len (max_region_len),
    .count_a        (count_a),
    .count_c        (count_c),
    .count_g        (count_g),
    .count_t        (count_t),
    .last_column    (last_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .region_start   (region_start),
    .region_length  (region_length),
    .region_valid   (region_valid),
    .overflow       (overflow),
    .last_result    (last_result)
  );

endmodule
